@@ design/mgpm_pkg.sv @@
package mgpm_pkg;

  // Fixed-point format and grid size.
  localparam int FRAC_BITS = 26;
  localparam int GRID_SIZE = 1024;

  // Field widths.
  localparam int IDX_W     = 10;
  localparam int COORD_W   = 32;
  localparam int SPACING_W = 31;
  localparam int ITER_W    = 10;
  localparam int RAD_W     = 5;
  localparam int PROD_W    = 2 * COORD_W;
  localparam int CPROD_W   = IDX_W + SPACING_W;
  localparam int CSUM_W    = CPROD_W + 2;

  // Configuration port.
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  typedef enum logic [2:0] {
    REG_CORNER_RE        = 3'd0,
    REG_CORNER_IM        = 3'd1,
    REG_STEP_RE          = 3'd2,
    REG_STEP_IM          = 3'd3,
    REG_MAX_ITERATIONS   = 3'd4,
    REG_ESCAPE_RADIUS_SQ = 3'd5,
    REG_MEMBER_RADIUS_SQ = 3'd6
  } reg_idx_t;

  localparam logic signed [COORD_W-1:0] RST_CORNER_RE = -32'sd100663296;
  localparam logic signed [COORD_W-1:0] RST_CORNER_IM = 32'sd80530637;
  localparam logic [SPACING_W-1:0]      RST_STEP_RE   = 31'd704643;
  localparam logic [SPACING_W-1:0]      RST_STEP_IM   = 31'd838861;
  localparam logic [ITER_W-1:0]         RST_MAX_ITER  = 10'd200;
  localparam logic [RAD_W-1:0]          RST_ESC_RAD   = 5'd25;
  localparam logic [RAD_W-1:0]          RST_MEM_RAD   = 5'd4;

  // Microcode control word.
  typedef enum logic [2:0] {
    OP_IDLE,
    OP_COORD_MUL,
    OP_COORD_ADD,
    OP_SQUARE,
    OP_ITER,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    WAIT_NONE,
    WAIT_INPUT,
    WAIT_OUTPUT
  } wait_t;

  typedef enum logic [1:0] {
    JMP_NEVER,
    JMP_ALWAYS,
    JMP_LOOP
  } jmp_t;

  localparam int UPC_W = 3;
  typedef logic [UPC_W-1:0] upc_t;

  typedef struct packed {
    op_t   op;
    wait_t wt;
    jmp_t  jc;
    upc_t  target;
  } uword_t;

  localparam upc_t UPC_WAIT  = 3'd0;
  localparam upc_t UPC_CMUL  = 3'd1;
  localparam upc_t UPC_CADD  = 3'd2;
  localparam upc_t UPC_SQ    = 3'd3;
  localparam upc_t UPC_ITER  = 3'd4;
  localparam upc_t UPC_EMIT  = 3'd5;

  // The control store: one word per step of the program.
  function automatic uword_t ucode(input upc_t pc);
    uword_t w;
    unique case (pc)
      UPC_WAIT: w = '{op: OP_IDLE,      wt: WAIT_INPUT,  jc: JMP_NEVER,  target: UPC_WAIT};
      UPC_CMUL: w = '{op: OP_COORD_MUL, wt: WAIT_NONE,   jc: JMP_NEVER,  target: UPC_WAIT};
      UPC_CADD: w = '{op: OP_COORD_ADD, wt: WAIT_NONE,   jc: JMP_NEVER,  target: UPC_WAIT};
      UPC_SQ:   w = '{op: OP_SQUARE,    wt: WAIT_NONE,   jc: JMP_NEVER,  target: UPC_WAIT};
      UPC_ITER: w = '{op: OP_ITER,      wt: WAIT_NONE,   jc: JMP_LOOP,   target: UPC_SQ};
      UPC_EMIT: w = '{op: OP_EMIT,      wt: WAIT_OUTPUT, jc: JMP_ALWAYS, target: UPC_WAIT};
      default:  w = '{op: OP_IDLE,      wt: WAIT_NONE,   jc: JMP_ALWAYS, target: UPC_WAIT};
    endcase
    return w;
  endfunction

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = PROD_W'({1'b0, {(COORD_W-1){1'b1}}});
    lo = -hi - PROD_W'(1);
    if (v > hi) begin
      return hi[COORD_W-1:0];
    end else if (v < lo) begin
      return lo[COORD_W-1:0];
    end
    return v[COORD_W-1:0];
  endfunction

endpackage

@@ design/mgpm_in_if.sv @@
interface mgpm_in_if;
  logic                           valid;
  logic                           ready;
  logic [mgpm_pkg::IDX_W-1:0]     column;
  logic [mgpm_pkg::IDX_W-1:0]     row;

  modport source (output valid, output column, output row, input ready);
  modport sink   (input valid, input column, input row, output ready);
endinterface

@@ design/mgpm_out_if.sv @@
interface mgpm_out_if;
  logic                               valid;
  logic                               ready;
  logic                               in_set;
  logic signed [mgpm_pkg::COORD_W-1:0] point_re;
  logic signed [mgpm_pkg::COORD_W-1:0] point_im;

  modport source (output valid, output in_set, output point_re, output point_im,
                  input ready);
  modport sink   (input valid, input in_set, input point_re, input point_im,
                  output ready);
endinterface

@@ design/mandelbrot_grid_point_membership.sv @@
// A point is taken in the wait step and its c is formed in the coordinate multiply
// and add steps; then the z = z^2 + c iterations run (at most max_iterations), each
// costing two steps of the loop (square through the multiplier bank, then update
// and test), before the emit step; no new point is taken until then.
// Reset (synchronous, rst_n low) returns the sequencer to its wait step, drops the
// result valid and loads every configuration register with its documented default.
module mandelbrot_grid_point_membership (
  input  logic                           clk,
  input  logic                           rst_n,
  mgpm_in_if.sink                        in_chan,
  mgpm_out_if.source                     out_chan,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mgpm_pkg::APB_AW-1:0]    paddr,
  input  logic [mgpm_pkg::APB_DW-1:0]    pwdata,
  output logic [mgpm_pkg::APB_DW-1:0]    prdata,
  output logic                           pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers. A write completes in the access phase; the word
  // index is taken from the address bits above the byte offset, and an index
  // past the last register is ignored.
  // ---------------------------------------------------------------------------
  logic signed [mgpm_pkg::COORD_W-1:0]   corner_re_r;
  logic signed [mgpm_pkg::COORD_W-1:0]   corner_im_r;
  logic [mgpm_pkg::SPACING_W-1:0]        step_re_r;
  logic [mgpm_pkg::SPACING_W-1:0]        step_im_r;
  logic [mgpm_pkg::ITER_W-1:0]           max_iter_r;
  logic [mgpm_pkg::RAD_W-1:0]            esc_rad_r;
  logic [mgpm_pkg::RAD_W-1:0]            mem_rad_r;

  logic                                  cfg_wr;
  mgpm_pkg::reg_idx_t                    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = mgpm_pkg::reg_idx_t'(paddr[mgpm_pkg::APB_AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corner_re_r <= mgpm_pkg::RST_CORNER_RE;
      corner_im_r <= mgpm_pkg::RST_CORNER_IM;
      step_re_r   <= mgpm_pkg::RST_STEP_RE;
      step_im_r   <= mgpm_pkg::RST_STEP_IM;
      max_iter_r  <= mgpm_pkg::RST_MAX_ITER;
      esc_rad_r   <= mgpm_pkg::RST_ESC_RAD;
      mem_rad_r   <= mgpm_pkg::RST_MEM_RAD;
    end else if (cfg_wr) begin
      case (cfg_idx)
        mgpm_pkg::REG_CORNER_RE:        corner_re_r <= pwdata;
        mgpm_pkg::REG_CORNER_IM:        corner_im_r <= pwdata;
        mgpm_pkg::REG_STEP_RE:          step_re_r   <= pwdata[mgpm_pkg::SPACING_W-1:0];
        mgpm_pkg::REG_STEP_IM:          step_im_r   <= pwdata[mgpm_pkg::SPACING_W-1:0];
        mgpm_pkg::REG_MAX_ITERATIONS:   max_iter_r  <= pwdata[mgpm_pkg::ITER_W-1:0];
        mgpm_pkg::REG_ESCAPE_RADIUS_SQ: esc_rad_r   <= pwdata[mgpm_pkg::RAD_W-1:0];
        mgpm_pkg::REG_MEMBER_RADIUS_SQ: mem_rad_r   <= pwdata[mgpm_pkg::RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Read data is a plain mux; unused indexes read as zero.
  always_comb begin
    case (cfg_idx)
      mgpm_pkg::REG_CORNER_RE:        prdata = corner_re_r;
      mgpm_pkg::REG_CORNER_IM:        prdata = corner_im_r;
      mgpm_pkg::REG_STEP_RE:          prdata = mgpm_pkg::APB_DW'(step_re_r);
      mgpm_pkg::REG_STEP_IM:          prdata = mgpm_pkg::APB_DW'(step_im_r);
      mgpm_pkg::REG_MAX_ITERATIONS:   prdata = mgpm_pkg::APB_DW'(max_iter_r);
      mgpm_pkg::REG_ESCAPE_RADIUS_SQ: prdata = mgpm_pkg::APB_DW'(esc_rad_r);
      mgpm_pkg::REG_MEMBER_RADIUS_SQ: prdata = mgpm_pkg::APB_DW'(mem_rad_r);
      default:                        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer. The program counter addresses the control store; each word
  // names the datapath operation, an optional wait on a handshake and a jump.
  // The only data-dependent branch is the iteration loop, which returns to the
  // squaring step until the point escapes or the iteration limit is reached.
  // ---------------------------------------------------------------------------
  mgpm_pkg::upc_t    pc_r;
  mgpm_pkg::upc_t    pc_nxt;
  mgpm_pkg::uword_t  uw;

  logic in_xfer;
  logic out_busy;
  logic hold;
  logic iter_exit;

  assign uw       = mgpm_pkg::ucode(pc_r);
  assign in_chan.ready = (uw.wt == mgpm_pkg::WAIT_INPUT);
  assign in_xfer  = in_chan.valid && in_chan.ready;
  assign out_busy = out_chan.valid && !out_chan.ready;
  assign hold     = ((uw.wt == mgpm_pkg::WAIT_INPUT)  && !in_chan.valid) ||
                    ((uw.wt == mgpm_pkg::WAIT_OUTPUT) && out_busy);

  always_comb begin
    if (hold) begin
      pc_nxt = pc_r;
    end else begin
      case (uw.jc)
        mgpm_pkg::JMP_ALWAYS: pc_nxt = uw.target;
        mgpm_pkg::JMP_LOOP:   pc_nxt = iter_exit ? pc_r + mgpm_pkg::upc_t'(1) : uw.target;
        default:              pc_nxt = pc_r + mgpm_pkg::upc_t'(1);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath.
  // ---------------------------------------------------------------------------
  logic [mgpm_pkg::IDX_W-1:0]            col_r;
  logic [mgpm_pkg::IDX_W-1:0]            row_r;
  logic [mgpm_pkg::IDX_W-1:0]            col_clamp;
  logic [mgpm_pkg::IDX_W-1:0]            row_clamp;
  logic [mgpm_pkg::CPROD_W-1:0]          cre_prod_r;
  logic [mgpm_pkg::CPROD_W-1:0]          cim_prod_r;
  logic signed [mgpm_pkg::CSUM_W-1:0]    cr_sum;
  logic signed [mgpm_pkg::CSUM_W-1:0]    ci_sum;
  logic signed [mgpm_pkg::COORD_W-1:0]   cr_r;
  logic signed [mgpm_pkg::COORD_W-1:0]   ci_r;
  logic signed [mgpm_pkg::COORD_W-1:0]   zr_r;
  logic signed [mgpm_pkg::COORD_W-1:0]   zi_r;
  logic signed [mgpm_pkg::PROD_W-1:0]    rr_r;
  logic signed [mgpm_pkg::PROD_W-1:0]    ii_r;
  logic signed [mgpm_pkg::PROD_W-1:0]    ri_r;
  logic signed [mgpm_pkg::PROD_W-1:0]    nr_wide;
  logic signed [mgpm_pkg::PROD_W-1:0]    ni_wide;
  logic [mgpm_pkg::PROD_W-1:0]           mag_now;
  logic [mgpm_pkg::PROD_W-1:0]           mag_r;
  logic [mgpm_pkg::PROD_W-1:0]           esc_lim;
  logic [mgpm_pkg::PROD_W-1:0]           mem_lim;
  logic [mgpm_pkg::ITER_W-1:0]           cnt_r;
  logic                                  out_valid_r;
  logic                                  in_set_r;
  logic signed [mgpm_pkg::COORD_W-1:0]   point_re_r;
  logic signed [mgpm_pkg::COORD_W-1:0]   point_im_r;

  // Indexes past the grid are pulled back to the last row or column.
  assign col_clamp = (32'(in_chan.column) >= mgpm_pkg::GRID_SIZE) ?
                     mgpm_pkg::IDX_W'(mgpm_pkg::GRID_SIZE - 1) : in_chan.column;
  assign row_clamp = (32'(in_chan.row) >= mgpm_pkg::GRID_SIZE) ?
                     mgpm_pkg::IDX_W'(mgpm_pkg::GRID_SIZE - 1) : in_chan.row;

  // The point c: real part grows with the column, imaginary part falls per row.
  assign cr_sum = mgpm_pkg::CSUM_W'(corner_re_r) + $signed({2'b00, cre_prod_r});
  assign ci_sum = mgpm_pkg::CSUM_W'(corner_im_r) - $signed({2'b00, cim_prod_r});

  // One iteration from the registered exact products. The arithmetic shift
  // rounds toward minus infinity; the cross term uses one bit less of shift
  // to pick up its factor of two.
  assign nr_wide = ((rr_r - ii_r) >>> mgpm_pkg::FRAC_BITS) + mgpm_pkg::PROD_W'(cr_r);
  assign ni_wide = (ri_r >>> (mgpm_pkg::FRAC_BITS - 1)) + mgpm_pkg::PROD_W'(ci_r);

  // The squares of the current z double as its squared magnitude, so the
  // escape test of one iteration rides on the squaring step of the next.
  assign mag_now   = $unsigned(rr_r) + $unsigned(ii_r);
  assign esc_lim   = mgpm_pkg::PROD_W'(esc_rad_r) << (2 * mgpm_pkg::FRAC_BITS);
  assign mem_lim   = mgpm_pkg::PROD_W'(mem_rad_r) << (2 * mgpm_pkg::FRAC_BITS);
  assign iter_exit = (mag_now > esc_lim) || (cnt_r == max_iter_r);

  // Control state: program counter, iteration count and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= mgpm_pkg::UPC_WAIT;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r <= pc_nxt;
      if (uw.op == mgpm_pkg::OP_COORD_ADD) begin
        cnt_r <= '0;
      end else if ((uw.op == mgpm_pkg::OP_ITER) && !iter_exit) begin
        cnt_r <= cnt_r + mgpm_pkg::ITER_W'(1);
      end
      if ((uw.op == mgpm_pkg::OP_EMIT) && !out_busy) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers; each step of the program drives one operation.
  always_ff @(posedge clk) begin
    case (uw.op)
      mgpm_pkg::OP_IDLE: begin
        if (in_xfer) begin
          col_r <= col_clamp;
          row_r <= row_clamp;
        end
      end
      mgpm_pkg::OP_COORD_MUL: begin
        cre_prod_r <= col_r * step_re_r;
        cim_prod_r <= row_r * step_im_r;
      end
      mgpm_pkg::OP_COORD_ADD: begin
        cr_r <= mgpm_pkg::sat32(mgpm_pkg::PROD_W'(cr_sum));
        ci_r <= mgpm_pkg::sat32(mgpm_pkg::PROD_W'(ci_sum));
        zr_r <= '0;
        zi_r <= '0;
      end
      mgpm_pkg::OP_SQUARE: begin
        rr_r <= zr_r * zr_r;
        ii_r <= zi_r * zi_r;
        ri_r <= zr_r * zi_r;
      end
      mgpm_pkg::OP_ITER: begin
        mag_r <= mag_now;
        if (!iter_exit) begin
          zr_r <= mgpm_pkg::sat32(nr_wide);
          zi_r <= mgpm_pkg::sat32(ni_wide);
        end
      end
      mgpm_pkg::OP_EMIT: begin
        if (!out_busy) begin
          in_set_r   <= (mag_r <= mem_lim);
          point_re_r <= cr_r;
          point_im_r <= ci_r;
        end
      end
      default: ;
    endcase
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.in_set   = in_set_r;
  assign out_chan.point_re = point_re_r;
  assign out_chan.point_im = point_im_r;

endmodule

@@ design/mgpm_checker.sv @@
module mgpm_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic                               out_in_set,
  input logic signed [mgpm_pkg::COORD_W-1:0] out_point_re,
  input logic signed [mgpm_pkg::COORD_W-1:0] out_point_im
);

  // A waiting result holds its value until it is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_in_set) &&
                                $stable(out_point_re) && $stable(out_point_im))
    else $error("result changed while stalled");

  // After a point is taken the block is busy for at least the coordinate steps.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("input taken again too soon");

  // A new result is only produced while the block is not taking input.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while idle");

  // Reset leaves the block ready for input with nothing to deliver.
  assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("bad state after reset");

endmodule

bind mandelbrot_grid_point_membership mgpm_checker u_mgpm_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_in_set   (out_chan.in_set),
  .out_point_re (out_chan.point_re),
  .out_point_im (out_chan.point_im)
);

@@ sim/tb_mandelbrot_grid_point_membership.sv @@
`timescale 1ns / 100ps

module tb_mandelbrot_grid_point_membership;
  import mgpm_pkg::*;

  // A code for a register address that maps to no register. Writes there must
  // leave every register alone.
  localparam logic [2:0] REG_UNMAPPED = 3'd7;

  // One judged grid point, as the result channel carries it.
  typedef struct packed {
    logic                      in_set;
    logic signed [COORD_W-1:0] re;
    logic signed [COORD_W-1:0] im;
  } membership_t;

  // One row of the directed table. A row is either a register write or a grid
  // point. Points with typed set hold their expected result in want. The others
  // are checked against the prediction.
  typedef struct packed {
    bit                 is_write;
    logic [2:0]         reg_sel;
    logic [31:0]        value;
    logic [IDX_W-1:0]   col;
    logic [IDX_W-1:0]   row;
    bit                 typed;
    membership_t        want;
  } plan_row_t;

  // Clock, reset and the stimulus-side signals. All of them are known from
  // time zero.
  logic clk;
  logic rst_n = 1'b0;

  logic              in_valid  = 1'b0;
  logic [IDX_W-1:0]  in_column = '0;
  logic [IDX_W-1:0]  in_row    = '0;
  logic              sink_ready = 1'b0;

  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [APB_AW-1:0] paddr   = '0;
  logic [APB_DW-1:0] pwdata  = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  mgpm_in_if  in_if ();
  mgpm_out_if out_if ();

  assign in_if.valid  = in_valid;
  assign in_if.column = in_column;
  assign in_if.row    = in_row;
  assign out_if.ready = sink_ready;

  mandelbrot_grid_point_membership u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Our own copy of the register file. It starts at the documented reset values
  // and follows every write that the port completes.
  logic signed [COORD_W-1:0] corner_re_q = -32'sd100663296;
  logic signed [COORD_W-1:0] corner_im_q = 32'sd80530637;
  logic [SPACING_W-1:0]      step_re_q   = 31'd704643;
  logic [SPACING_W-1:0]      step_im_q   = 31'd838861;
  logic [ITER_W-1:0]         max_iter_q  = 10'd200;
  logic [RAD_W-1:0]          escape_q    = 5'd25;
  logic [RAD_W-1:0]          member_q    = 5'd4;

  // Results still owed by the block, oldest first.
  membership_t expected_points[$];
  plan_row_t   directed_plan[$];

  int  mismatches    = 0;
  int  results_seen  = 0;
  int  points_sent   = 0;
  int  writes_done   = 0;
  bit  idle_on       = 1'b0;
  bit  stall_on      = 1'b0;
  int  sink_gap      = 0;

  // The clock runs with an 8 ns period.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Clamp a wide signed value to the signed 32-bit coordinate range.
  function automatic longint clip_to_coord(input longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Work out the verdict for one grid point under the current registers.
  // The point is c = corner + col*step_re - i*row*step_im, saturated per
  // component. Then z = z^2 + c runs from zero until the iteration limit or
  // until |z|^2 passes the escape bound. Products are exact, scaled back by a
  // flooring shift, and each new component is saturated. The squared magnitude
  // is compared exactly against the whole-number bounds.
  function automatic membership_t judge_point(input logic [IDX_W-1:0] col,
                                              input logic [IDX_W-1:0] row);
    longint            ccol;
    longint            crow;
    longint            cr;
    longint            ci;
    longint            zr;
    longint            zi;
    longint            rr;
    longint            ii;
    longint            ri;
    longint unsigned   mag;
    longint unsigned   escape_bound;
    longint unsigned   member_bound;
    int unsigned       k;
    bit                escaped;
    membership_t       verdict;
    ccol = (col >= GRID_SIZE) ? GRID_SIZE - 1 : longint'(col);
    crow = (row >= GRID_SIZE) ? GRID_SIZE - 1 : longint'(row);
    cr = clip_to_coord(longint'(corner_re_q) + ccol * longint'(step_re_q));
    ci = clip_to_coord(longint'(corner_im_q) - crow * longint'(step_im_q));
    escape_bound = longint'(escape_q) << (2 * FRAC_BITS);
    member_bound = longint'(member_q) << (2 * FRAC_BITS);
    zr = 0;
    zi = 0;
    mag = 0;
    k = 0;
    escaped = 1'b0;
    while (k < max_iter_q && !escaped) begin
      rr = zr * zr;
      ii = zi * zi;
      ri = zr * zi;
      // The cross term 2*re*im is the product shifted one place less.
      zr = clip_to_coord(((rr - ii) >>> FRAC_BITS) + cr);
      zi = clip_to_coord((ri >>> (FRAC_BITS - 1)) + ci);
      mag = longint'(zr * zr) + longint'(zi * zi);
      escaped = (mag > escape_bound);
      k++;
    end
    verdict.in_set = (mag <= member_bound);
    verdict.re     = cr[COORD_W-1:0];
    verdict.im     = ci[COORD_W-1:0];
    return verdict;
  endfunction

  // Mirror a completed register write. Narrow registers keep their low bits.
  // An address with no register behind it changes nothing.
  function automatic void apply_write(input logic [2:0] sel, input logic [31:0] value);
    case (sel)
      REG_CORNER_RE:        corner_re_q = value;
      REG_CORNER_IM:        corner_im_q = value;
      REG_STEP_RE:          step_re_q   = value[SPACING_W-1:0];
      REG_STEP_IM:          step_im_q   = value[SPACING_W-1:0];
      REG_MAX_ITERATIONS:   max_iter_q  = value[ITER_W-1:0];
      REG_ESCAPE_RADIUS_SQ: escape_q    = value[RAD_W-1:0];
      REG_MEMBER_RADIUS_SQ: member_q    = value[RAD_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void plan_write(input logic [2:0] sel, input logic [31:0] value);
    plan_row_t r;
    r = '0;
    r.is_write = 1'b1;
    r.reg_sel  = sel;
    r.value    = value;
    directed_plan.push_back(r);
  endfunction

  function automatic void plan_point(input logic [IDX_W-1:0] col,
                                     input logic [IDX_W-1:0] row,
                                     input bit typed, input logic in_set,
                                     input logic signed [COORD_W-1:0] re,
                                     input logic signed [COORD_W-1:0] im);
    plan_row_t r;
    r = '0;
    r.col         = col;
    r.row         = row;
    r.typed       = typed;
    r.want.in_set = in_set;
    r.want.re     = re;
    r.want.im     = im;
    directed_plan.push_back(r);
  endfunction

  // Offer one grid point and hold it until the block takes it. The expected
  // result is queued at the transfer, under the registers in force then.
  task automatic send_point(input logic [IDX_W-1:0] col, input logic [IDX_W-1:0] row,
                            input bit typed, input membership_t want);
    in_valid  <= 1'b1;
    in_column <= col;
    in_row    <= row;
    do @(posedge clk); while (!in_if.ready);
    if (typed) begin
      expected_points.push_back(want);
    end else begin
      expected_points.push_back(judge_point(col, row));
    end
    points_sent++;
  endtask

  // Random gap on the input side after a transfer, when idling is on.
  task automatic maybe_idle_sender();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // Stop offering points and wait until every owed result has come back. The
  // block produces a result for every point, so it is idle once the queue is
  // empty; a spare wait at the end lets the sequencer settle in its wait step.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write: a setup phase, then an access phase held until pready.
  // An idle wait afterwards keeps back-to-back writes from reassigning psel
  // in the same time step.
  task automatic write_reg(input logic [2:0] sel, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    apply_write(sel, value);
    writes_done++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // The result side. When stalling is on, ready drops at random, in bursts;
  // otherwise it stays high.
  always @(posedge clk) begin
    if (sink_gap > 0) begin
      sink_gap   <= sink_gap - 1;
      sink_ready <= 1'b0;
    end else if (stall_on && $urandom_range(0, 5) == 0) begin
      sink_gap   <= $urandom_range(0, 14);
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= 1'b1;
    end
  end

  // Every result transfer is compared, field by field, with the oldest
  // expectation. A result that nobody is waiting for is a failure too.
  always @(posedge clk) begin
    membership_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_points.size() == 0) begin
        $display("%0t: result with nothing expected: in_set=%0b re=%0d im=%0d",
                 $time, out_if.in_set, out_if.point_re, out_if.point_im);
        mismatches++;
      end else begin
        want = expected_points.pop_front();
        results_seen++;
        if (out_if.in_set !== want.in_set) begin
          $display("%0t: in_set expected %0b, got %0b (point %0d, %0d)",
                   $time, want.in_set, out_if.in_set, want.re, want.im);
          mismatches++;
        end
        if (out_if.point_re !== want.re) begin
          $display("%0t: point_re expected %0d, got %0d", $time, want.re, out_if.point_re);
          mismatches++;
        end
        if (out_if.point_im !== want.im) begin
          $display("%0t: point_im expected %0d, got %0d", $time, want.im, out_if.point_im);
          mismatches++;
        end
      end
    end
  end

  // Safety net: a hung handshake ends the run. This is many times the slowest
  // legal run.
  initial begin
    #8_000_000;
    $display("[mandelbrot_grid_point_membership] ERROR");
    $finish;
  end

  initial begin
    plan_row_t   r;
    membership_t none;
    logic [31:0] v_cre;
    logic [31:0] v_cim;
    logic [31:0] v_sre;
    logic [31:0] v_sim;
    logic [31:0] v_iter;
    logic [31:0] v_esc;
    logic [31:0] v_mem;
    int          phase_items;
    int          phase;
    int          n;

    none = '0;

    // Directed table. It starts under the reset registers. Then it moves to the
    // zero iteration limit, corners and steps that push the point out of range
    // on both axes, the origin at the full limit, zero escape and membership
    // bounds, the orbit fixed at -2, a write to an unmapped address, and finally
    // back to the default view.
    plan_point(10'd0,    10'd0,    1'b1, 1'b0, -32'sd100663296, 32'sd80530637);
    plan_point(10'd1023, 10'd1023, 1'b0, 1'b0, '0, '0);
    plan_point(10'd0,    10'd1023, 1'b0, 1'b0, '0, '0);
    plan_point(10'd1023, 10'd0,    1'b0, 1'b0, '0, '0);
    plan_point(10'd512,  10'd96,   1'b0, 1'b0, '0, '0);
    // With no iterations z stays zero, so every point is a member.
    plan_write(REG_MAX_ITERATIONS, 32'd0);
    plan_point(10'd5,    10'd7,    1'b1, 1'b1, -32'sd97140081, 32'sd74658610);
    plan_write(REG_CORNER_RE, 32'h7FFF_FFFF);
    plan_write(REG_STEP_RE,   32'hFFFF_FFFF);
    plan_point(10'd1023, 10'd0,    1'b1, 1'b1, 32'sd2147483647, 32'sd80530637);
    plan_write(REG_CORNER_IM, 32'h8000_0000);
    plan_write(REG_STEP_IM,   32'h7FFF_FFFF);
    plan_point(10'd0,    10'd1023, 1'b1, 1'b1, 32'sd2147483647, -32'sd2147483648);
    plan_point(10'd1023, 10'd1023, 1'b1, 1'b1, 32'sd2147483647, -32'sd2147483648);
    plan_write(REG_CORNER_RE, 32'h8000_0000);
    plan_write(REG_STEP_RE,   32'h0000_0000);
    plan_point(10'd1023, 10'd5,    1'b1, 1'b1, -32'sd2147483648, -32'sd2147483648);
    // The origin never moves, whatever the limit.
    plan_write(REG_CORNER_RE, 32'h0000_0000);
    plan_write(REG_CORNER_IM, 32'h0000_0000);
    plan_write(REG_STEP_IM,   32'h0000_0000);
    plan_write(REG_MAX_ITERATIONS, 32'd1023);
    plan_point(10'd0,    10'd0,    1'b1, 1'b1, 32'sd0, 32'sd0);
    plan_write(REG_ESCAPE_RADIUS_SQ, 32'd0);
    plan_write(REG_MEMBER_RADIUS_SQ, 32'd0);
    plan_point(10'd1023, 10'd1023, 1'b1, 1'b1, 32'sd0, 32'sd0);
    // A zero escape bound stops at the first nonzero magnitude: c = 1.
    plan_write(REG_CORNER_RE, 32'h0400_0000);
    plan_point(10'd3,    10'd9,    1'b1, 1'b0, 32'sd67108864, 32'sd0);
    // c = -2 settles at z = 2, so |z|^2 = 4 for the whole run.
    plan_write(REG_ESCAPE_RADIUS_SQ, 32'd31);
    plan_write(REG_MEMBER_RADIUS_SQ, 32'd31);
    plan_write(REG_CORNER_RE, 32'hF800_0000);
    plan_point(10'd0,    10'd0,    1'b1, 1'b1, -32'sd134217728, 32'sd0);
    plan_write(REG_MEMBER_RADIUS_SQ, 32'd1);
    plan_write(REG_MAX_ITERATIONS, 32'd1);
    plan_point(10'd0,    10'd0,    1'b1, 1'b0, -32'sd134217728, 32'sd0);
    plan_write(REG_UNMAPPED, 32'hFFFF_FFFF);
    plan_point(10'd0,    10'd0,    1'b1, 1'b0, -32'sd134217728, 32'sd0);
    plan_write(REG_CORNER_RE, 32'hFA00_0000);
    plan_write(REG_CORNER_IM, 32'h04CC_CCCD);
    plan_write(REG_STEP_RE,   32'd704643);
    plan_write(REG_STEP_IM,   32'd838861);
    plan_write(REG_MAX_ITERATIONS, 32'd48);
    plan_write(REG_ESCAPE_RADIUS_SQ, 32'd4);
    plan_write(REG_MEMBER_RADIUS_SQ, 32'd4);
    plan_point(10'd100,  10'd40,   1'b0, 1'b0, '0, '0);
    plan_point(10'd143,  10'd96,   1'b0, 1'b0, '0, '0);
    plan_point(10'd200,  10'd200,  1'b0, 1'b0, '0, '0);
    plan_point(10'd300,  10'd120,  1'b0, 1'b0, '0, '0);
    plan_point(10'd64,   10'd500,  1'b0, 1'b0, '0, '0);
    plan_point(10'd1,    10'd1022, 1'b0, 1'b0, '0, '0);

    // Reset is held once, at the start.
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Walk the directed table with stalls on both sides. Every write waits for
    // the block to go idle, so the sender pauses until all results are back.
    idle_on  = 1'b1;
    stall_on = 1'b1;
    foreach (directed_plan[i]) begin
      r = directed_plan[i];
      if (r.is_write) begin
        drain_results();
        write_reg(r.reg_sel, r.value);
      end else begin
        send_point(r.col, r.row, r.typed, r.want);
        maybe_idle_sender();
      end
    end

    // Random phases. Each one loads a fresh set of registers and then streams
    // points. Most phases look at the familiar region with modest limits so
    // that orbits are short. One phase runs a few points at the full limit;
    // another uses raw random registers, which mostly saturate and escape at
    // once. The last phase has no idling on either side. Unused upper bits of
    // the narrow registers carry random junk, which the block must drop.
    for (phase = 0; phase < 10; phase++) begin
      drain_results();
      idle_on  = (phase != 9) && ($urandom_range(0, 3) != 0);
      stall_on = (phase != 9) && ($urandom_range(0, 3) != 0);
      if (phase == 6) begin
        v_cre  = $urandom;
        v_cim  = $urandom;
        v_sre  = $urandom;
        v_sim  = $urandom;
        v_iter = ($urandom & 32'hFFFF_FC00) | $urandom_range(0, 12);
      end else begin
        v_cre  = $urandom_range(0, 134217728) - 32'd167772160;
        v_cim  = $urandom_range(0, 100663296);
        v_sre  = ($urandom & 32'h8000_0000) | $urandom_range(0, 300000);
        v_sim  = ($urandom & 32'h8000_0000) | $urandom_range(0, 300000);
        if (phase == 3) begin
          v_iter = 32'd1023;
        end else if ($urandom_range(0, 7) == 0) begin
          v_iter = ($urandom & 32'hFFFF_FC00) | $urandom_range(0, 3);
        end else begin
          v_iter = ($urandom & 32'hFFFF_FC00) | $urandom_range(8, 64);
        end
      end
      v_esc = ($urandom & 32'hFFFF_FFE0) | $urandom_range(0, 31);
      v_mem = ($urandom & 32'hFFFF_FFE0) | $urandom_range(0, 31);
      write_reg(REG_CORNER_RE, v_cre);
      write_reg(REG_CORNER_IM, v_cim);
      write_reg(REG_STEP_RE, v_sre);
      write_reg(REG_STEP_IM, v_sim);
      write_reg(REG_MAX_ITERATIONS, v_iter);
      write_reg(REG_ESCAPE_RADIUS_SQ, v_esc);
      write_reg(REG_MEMBER_RADIUS_SQ, v_mem);
      phase_items = (phase == 3) ? 6 : 69;
      for (n = 0; n < phase_items; n++) begin
        send_point(IDX_W'($urandom_range(0, 1023)), IDX_W'($urandom_range(0, 1023)),
                   1'b0, none);
        maybe_idle_sender();
      end
    end

    // Let the last results come home, then give the block time to show any
    // stray extra transfer.
    drain_results();
    repeat (2 * max_iter_q + 8) @(posedge clk);

    $display("Judged %0d grid points across %0d register writes; %0d results compared.",
             points_sent, writes_done, results_seen);
    $display("Covered saturated corners, zero limits and bounds, and a full-limit phase.");
    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("[mandelbrot_grid_point_membership] OK");
    end else begin
      $display("%0d mismatches, %0d results still owed", mismatches, expected_points.size());
      $display("[mandelbrot_grid_point_membership] ERROR");
    end
    $finish;
  end

endmodule
